>>> hw/rtl/bdq_pkg.sv
// Package for the bounded deque engine.
// Holds sizes, field widths, request codes and status codes.
// No dependencies.

package bdq_pkg;

    // Storage size and word width.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // Derived storage widths.
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Port field widths.
    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 4;
    localparam int STAT_W = 3;
    localparam int LEN_W  = 5;

    // Width that holds both an index field and a count for comparison.
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // Request codes.
    localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;
    localparam logic [OP_W-1:0] OP_DEL  = 2'd3;

    // End select codes.
    localparam logic END_HEAD = 1'b0;
    localparam logic END_TAIL = 1'b1;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

endpackage

>>> hw/rtl/bounded_deque_engine.sv
// Bounded deque engine: a double-ended queue of words kept in a ring memory.
// Depends on bdq_pkg for sizes and codes.
//
// Channel   Direction  Handshake            Word
// request   in         start && !busy       req_type, end_sel, value, index
// result    out        done (one cycle)     status, data_out, length
//
// A put, or any request that fails its checks, gives its result in the
// cycle after it is taken. A remove at an end or a read waits in S_READ
// for the registered read port of the entry memory. A remove by value scans
// one entry a cycle through the single read port until it matches, then
// closes the gap at one entry a cycle. busy is high while a request is in
// progress. Reset clears the head pointer and the count; the entry memory
// needs no clearing. The receiver cannot stall the result.

module bounded_deque_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bdq_pkg::OP_W-1:0]      req_type,
    input  logic                          end_sel,
    input  logic [bdq_pkg::VAL_W-1:0]     value,
    input  logic [bdq_pkg::IDX_W-1:0]     index,
    output logic                          done,
    output logic [bdq_pkg::STAT_W-1:0]    status,
    output logic [bdq_pkg::VAL_W-1:0]     data_out,
    output logic [bdq_pkg::LEN_W-1:0]     length
);

    import bdq_pkg::*;

    // Sequencer state codes.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SRCH  = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    // Ring position of an offset from a base, wrapped at DEPTH.
    function automatic logic [PTR_W-1:0] ring_pos(input logic [PTR_W-1:0] base,
                                                   input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W+1)'(DEPTH))
        begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Control and response registers.
    logic [1:0]            state_reg, state_next;
    logic [PTR_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [PTR_W-1:0]      k_reg, k_next;
    logic [PTR_W-1:0]      p_reg, p_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic                  end_reg, end_next;
    logic                  done_reg, done_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [LEN_W-1:0]      length_reg, length_next;

    // Entry memory and its access signals.
    logic [DATA_WIDTH-1:0] entry_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [PTR_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [PTR_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    // Helper values for the sequencer.
    logic                  accept;
    logic [CNT_W-1:0]      count_dec;
    logic [PTR_W-1:0]      last_pos;
    logic [CMP_W-1:0]      idx_ext;
    logic [PTR_W-1:0]      read_lpos;
    logic [PTR_W-1:0]      scan_lpos;
    logic [PTR_W-1:0]      scan_lpos_nx;
    logic [PTR_W-1:0]      k_inc;
    logic [CNT_W:0]        hit_plus1;
    logic [CNT_W:0]        p_plus2;

    assign accept    = start && (state_reg == S_IDLE);
    assign count_dec = count_reg - CNT_W'(1);
    assign last_pos  = count_dec[PTR_W-1:0];
    assign idx_ext   = CMP_W'(index);
    assign read_lpos = (end_sel == END_TAIL) ? (last_pos - idx_ext[PTR_W-1:0])
                                             : idx_ext[PTR_W-1:0];
    assign k_inc        = k_reg + PTR_W'(1);
    assign scan_lpos    = (end_reg == END_TAIL) ? (last_pos - k_reg) : k_reg;
    assign scan_lpos_nx = (end_reg == END_TAIL) ? (last_pos - k_inc) : k_inc;
    assign hit_plus1    = (CNT_W+1)'(scan_lpos) + (CNT_W+1)'(1);
    assign p_plus2      = (CNT_W+1)'(p_reg) + (CNT_W+1)'(2);

    // Sequencer: decodes requests, drives the memory ports and forms results.
    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        p_next      = p_reg;
        word_next   = word_reg;
        end_next    = end_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        data_next   = data_reg;
        length_next = length_reg;
        rd_addr     = front_reg;
        mem_we      = 1'b0;
        wr_addr     = front_reg;
        wr_data     = value[DATA_WIDTH-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        OP_PUT:
                        begin
                            done_next = 1'b1;
                            data_next = '0;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                                length_next = LEN_W'(count_reg);
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                if (end_sel == END_TAIL)
                                begin
                                    wr_addr = ring_pos(front_reg, count_reg[PTR_W-1:0]);
                                end
                                else
                                begin
                                    front_next = (front_reg == '0) ? PTR_W'(DEPTH - 1)
                                                                   : front_reg - PTR_W'(1);
                                    wr_addr    = front_next;
                                end
                                count_next  = count_reg + CNT_W'(1);
                                status_next = ST_OK;
                                length_next = LEN_W'(count_next);
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                                data_next   = '0;
                                length_next = LEN_W'(count_reg);
                            end
                            else
                            begin
                                if (end_sel == END_TAIL)
                                begin
                                    rd_addr = ring_pos(front_reg, last_pos);
                                end
                                else
                                begin
                                    rd_addr    = front_reg;
                                    front_next = ring_pos(front_reg, PTR_W'(1));
                                end
                                count_next = count_dec;
                                state_next = S_READ;
                            end
                        end
                        OP_READ:
                        begin
                            if (idx_ext >= CMP_W'(count_reg))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_RANGE;
                                data_next   = '0;
                                length_next = LEN_W'(count_reg);
                            end
                            else
                            begin
                                rd_addr    = ring_pos(front_reg, read_lpos);
                                state_next = S_READ;
                            end
                        end
                        OP_DEL:
                        begin
                            word_next = value[DATA_WIDTH-1:0];
                            end_next  = end_sel;
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOTFOUND;
                                data_next   = '0;
                                length_next = LEN_W'(count_reg);
                            end
                            else
                            begin
                                rd_addr = (end_sel == END_TAIL) ? ring_pos(front_reg, last_pos)
                                                                : front_reg;
                                k_next     = '0;
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Memory word is ready: return it.
            S_READ:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                data_next   = rd_data_reg;
                length_next = LEN_W'(count_reg);
                state_next  = S_IDLE;
            end

            // Compare one entry a cycle while the next one is being read.
            S_SRCH:
            begin
                if (rd_data_reg == word_reg)
                begin
                    if (hit_plus1 < (CNT_W+1)'(count_reg))
                    begin
                        rd_addr    = ring_pos(front_reg, hit_plus1[PTR_W-1:0]);
                        p_next     = scan_lpos;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next  = count_dec;
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        data_next   = word_reg;
                        length_next = LEN_W'(count_dec);
                        state_next  = S_IDLE;
                    end
                end
                else if ((CNT_W+1)'(k_reg) + (CNT_W+1)'(1) == (CNT_W+1)'(count_reg))
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOTFOUND;
                    data_next   = '0;
                    length_next = LEN_W'(count_reg);
                    state_next  = S_IDLE;
                end
                else
                begin
                    k_next  = k_inc;
                    rd_addr = ring_pos(front_reg, scan_lpos_nx);
                end
            end

            // Move entry p+1 down to p while entry p+2 is being read.
            S_SHIFT:
            begin
                mem_we  = 1'b1;
                wr_addr = ring_pos(front_reg, p_reg);
                wr_data = rd_data_reg;
                if (p_plus2 < (CNT_W+1)'(count_reg))
                begin
                    rd_addr = ring_pos(front_reg, p_plus2[PTR_W-1:0]);
                    p_next  = p_reg + PTR_W'(1);
                end
                else
                begin
                    count_next  = count_dec;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    data_next   = word_reg;
                    length_next = LEN_W'(count_dec);
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        p_reg      <= p_next;
        word_reg   <= word_next;
        end_reg    <= end_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        length_reg <= length_next;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    // Output ports.
    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign data_out = VAL_W'(data_reg);
    assign length   = length_reg;

    // The count never exceeds the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count exceeds depth");

    // A failed request never returns a data word.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != ST_OK)) |-> (data_reg == '0))
        else $error("data word on failed request");

    // A put finishes in the following cycle.
    a_put_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == OP_PUT)) |=> (done_reg && (state_reg == S_IDLE)))
        else $error("put did not finish in one cycle");

    // Closing a gap needs at least two entries.
    a_shift_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (count_reg >= CNT_W'(2)))
        else $error("shift with fewer than two entries");

endmodule
